[rtl/sepu_pkg.sv]
package sepu_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned MIN_W      = 16;
  localparam int unsigned GAP_MS_W   = 16;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // Edge distance counter and T-state conversion
  localparam int unsigned DELTA_W         = 27;
  localparam int unsigned TSTATE_CLOCK_HZ = 3500000;
  localparam int unsigned CLK_W           = $clog2(TSTATE_CLOCK_HZ + 1);
  localparam int unsigned NUM_W           = DELTA_W + CLK_W + 1;
  localparam int unsigned MIN_RATE        = 8000;
  localparam int unsigned RATE_FLOOR_LOG2 = $clog2(MIN_RATE + 1) - 1;
  localparam int unsigned TST_W           = NUM_W - RATE_FLOOR_LOG2 + 1;
  localparam int unsigned DIV_CNT_W       = $clog2(NUM_W);
  localparam int unsigned TSTATE_PER_MS   = TSTATE_CLOCK_HZ / 1000;
  localparam int unsigned GAP_T_W         = GAP_MS_W + $clog2(TSTATE_PER_MS + 1);

  // Reset values of the configuration registers
  localparam logic signed [THR_W-1:0] HIGH_RESET   = 16'sd4096;
  localparam logic signed [THR_W-1:0] LOW_RESET    = -16'sd4096;
  localparam logic [RATE_W-1:0]       RATE_RESET   = 18'd44100;
  localparam logic [MIN_W-1:0]        MIN_RESET    = 16'd0;
  localparam logic [GAP_T_W-1:0]      GAP_T_RESET  = GAP_T_W'(500 * TSTATE_PER_MS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS   = 3'd4;

  typedef enum logic [1:0] {
    LATCH_NONE = 2'd0,
    LATCH_HIGH = 2'd1,
    LATCH_LOW  = 2'd2
  } latch_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_POST,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_DIV,
    CV_DONE
  } conv_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage

[rtl/sepu_in_if.sv]
interface sepu_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sepu_pkg::SAMPLE_W-1:0]   sample;
  logic                                   end_of_capture;

  modport source (output valid, output sample, output end_of_capture, input ready);
  modport sink   (input valid, input sample, input end_of_capture, output ready);
endinterface

[rtl/sepu_out_if.sv]
interface sepu_out_if;
  logic                          valid;
  logic                          ready;
  logic [sepu_pkg::DUR_W-1:0]    duration_tstates;
  logic                          is_gap;
  logic [sepu_pkg::CNT_W-1:0]    gap_total;
  logic [sepu_pkg::CNT_W-1:0]    edge_total;
  logic                          last;

  modport source (output valid, output duration_tstates, output is_gap, output gap_total,
                  output edge_total, output last, input ready);
  modport sink   (input valid, input duration_tstates, input is_gap, input gap_total,
                  input edge_total, input last, output ready);
endinterface

[rtl/schmitt_edge_to_tstate_pulses_unit.sv]
// Flow: a sample that needs no T-state conversion is taken in ST_IDLE; one that
//   needs one waits in ST_CONV on the multiply and bit-serial divider in sepu_conv,
//   then passes ST_POST, which decides whether its entries are offered in ST_EMIT.
// Throughput: one sample at a time; a new sample is taken once all entries of
//   the previous one are transferred.
// Reset: rst_ni clears trigger, counters and runt carry and restores register defaults.
module schmitt_edge_to_tstate_pulses_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sepu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sepu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sepu_in_if.sink                            in_if,
  sepu_out_if.source                         out_if
);

  localparam logic [sepu_pkg::TST_W-1:0] DUR_MAX_T =
    sepu_pkg::TST_W'({sepu_pkg::DUR_W{1'b1}});
  localparam logic [sepu_pkg::DELTA_W-1:0] DELTA_MAX = '1;

  // ---------------------------------------------------------------------
  // Configuration registers. Rate is stored already clamped, and the gap
  // level is kept in T-states so no multiply sits in the emit path.
  // ---------------------------------------------------------------------
  logic signed [sepu_pkg::THR_W-1:0] hi_thr_q;
  logic signed [sepu_pkg::THR_W-1:0] lo_thr_q;
  logic [sepu_pkg::RATE_W-1:0]       rate_q;
  logic [sepu_pkg::MIN_W-1:0]        min_sig_q;
  logic [sepu_pkg::GAP_T_W-1:0]      gap_t_q;
  logic [sepu_pkg::GAP_T_W-1:0]      gap_t_new;

  assign gap_t_new = sepu_pkg::GAP_T_W'(cfg_data_i[sepu_pkg::GAP_MS_W-1:0])
                   * sepu_pkg::GAP_T_W'(sepu_pkg::TSTATE_PER_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_thr_q  <= sepu_pkg::HIGH_RESET;
      lo_thr_q  <= sepu_pkg::LOW_RESET;
      rate_q    <= sepu_pkg::RATE_RESET;
      min_sig_q <= sepu_pkg::MIN_RESET;
      gap_t_q   <= sepu_pkg::GAP_T_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sepu_pkg::CFG_HIGH_THR: hi_thr_q  <= cfg_data_i[sepu_pkg::THR_W-1:0];
        sepu_pkg::CFG_LOW_THR:  lo_thr_q  <= cfg_data_i[sepu_pkg::THR_W-1:0];
        sepu_pkg::CFG_RATE: begin
          // Clamp low rates, zero included, to the minimum.
          rate_q <= (cfg_data_i < sepu_pkg::RATE_W'(sepu_pkg::MIN_RATE)) ?
                    sepu_pkg::RATE_W'(sepu_pkg::MIN_RATE) : cfg_data_i;
        end
        sepu_pkg::CFG_MIN_SIG:  min_sig_q <= cfg_data_i[sepu_pkg::MIN_W-1:0];
        sepu_pkg::CFG_GAP_MS:   gap_t_q   <= gap_t_new;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------
  sepu_pkg::state_e            state_q, state_d;
  sepu_pkg::latch_e            latch_q, latch_d;
  logic                        edge_seen_q, edge_seen_d;
  logic [sepu_pkg::DELTA_W-1:0] delta_q, delta_d;
  logic [sepu_pkg::MIN_W-1:0]   runt_q, runt_d;
  logic [sepu_pkg::CNT_W-1:0]   gap_cnt_q, gap_cnt_d;
  logic [sepu_pkg::CNT_W-1:0]   edge_cnt_q, edge_cnt_d;
  logic                        hold_q, hold_d;    // current entries are a trailing hold
  logic                        eoc_q, eoc_d;      // sample in work ends the capture
  logic                        extra_q, extra_d;  // zero-length hold follows the edge
  logic [sepu_pkg::TST_W-1:0]   remain_q, remain_d;

  // Input decode
  logic                        in_xfer;
  logic                        out_xfer;
  logic [sepu_pkg::DELTA_W-1:0] delta_inc;
  logic                        go_hi, go_lo, edge_det;
  logic                        conv_needed;
  logic                        first_hold_zero;
  logic                        gap_t_zero;

  assign in_xfer  = in_if.valid & in_if.ready;
  assign out_xfer = out_if.valid & out_if.ready;

  // Advance the distance counter only once an edge has started timing; saturate.
  assign delta_inc = (edge_seen_q && delta_q != DELTA_MAX) ? delta_q + 1'b1 : delta_q;

  // High test wins when a sample clears both bands.
  assign go_hi = (latch_q == sepu_pkg::LATCH_NONE || latch_q == sepu_pkg::LATCH_LOW)
              && (in_if.sample > hi_thr_q);
  assign go_lo = !go_hi
              && (latch_q == sepu_pkg::LATCH_NONE || latch_q == sepu_pkg::LATCH_HIGH)
              && (in_if.sample < lo_thr_q);
  assign edge_det   = go_hi | go_lo;
  assign gap_t_zero = gap_t_q == '0;

  // A later edge, or end of capture while timing, needs a conversion.
  assign conv_needed = edge_seen_q && (edge_det || in_if.end_of_capture);
  // First edge on the final sample: the hold is zero long, emitted only
  // when the gap level is zero.
  assign first_hold_zero = edge_det && !edge_seen_q && in_if.end_of_capture && gap_t_zero;

  // ---------------------------------------------------------------------
  // Conversion unit
  // ---------------------------------------------------------------------
  logic                       conv_start;
  logic                       conv_done;
  logic [sepu_pkg::TST_W-1:0] conv_quot;

  sepu_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .delta_i (delta_inc),
    .rate_i  (rate_q),
    .done_o  (conv_done),
    .quot_o  (conv_quot)
  );

  // Post-conversion decisions
  logic [sepu_pkg::TST_W-1:0] t_sum;
  logic                       t_is_runt;
  logic                       t_ge_gap;
  logic                       emit_post;

  assign t_sum     = conv_quot + sepu_pkg::TST_W'(runt_q);
  assign t_is_runt = t_sum < sepu_pkg::TST_W'(min_sig_q);
  assign t_ge_gap  = t_sum >= sepu_pkg::TST_W'(gap_t_q);
  // A runt on the final sample becomes the hold on its own.
  assign emit_post = hold_q ? t_ge_gap : (t_is_runt ? (eoc_q && t_ge_gap) : 1'b1);

  // Entry in emission: chop at the 32-bit limit
  logic [sepu_pkg::DUR_W-1:0] entry;
  logic                       more_chunks;
  logic                       entry_gap;
  logic                       out_last;

  assign more_chunks = remain_q > DUR_MAX_T;
  assign entry       = more_chunks ? {sepu_pkg::DUR_W{1'b1}} : remain_q[sepu_pkg::DUR_W-1:0];
  assign entry_gap   = hold_q || (entry >= sepu_pkg::DUR_W'(gap_t_q));
  assign out_last    = !more_chunks && !extra_q;

  // ---------------------------------------------------------------------
  // Control: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      sepu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (conv_needed) begin
            state_d = sepu_pkg::ST_CONV;
          end else if (first_hold_zero) begin
            state_d = sepu_pkg::ST_EMIT;
          end
        end
      end
      sepu_pkg::ST_CONV: if (conv_done) state_d = sepu_pkg::ST_POST;
      sepu_pkg::ST_POST: state_d = emit_post ? sepu_pkg::ST_EMIT : sepu_pkg::ST_IDLE;
      sepu_pkg::ST_EMIT: if (out_xfer && out_last) state_d = sepu_pkg::ST_IDLE;
      default:           state_d = sepu_pkg::ST_IDLE;
    endcase
  end

  // Control: outputs
  always_comb begin
    in_if.ready  = state_q == sepu_pkg::ST_IDLE;
    out_if.valid = state_q == sepu_pkg::ST_EMIT;
    conv_start   = (state_q == sepu_pkg::ST_IDLE) && in_xfer && conv_needed;
  end

  assign out_if.duration_tstates = entry;
  assign out_if.is_gap           = entry_gap;
  assign out_if.gap_total        = entry_gap ? sepu_pkg::sat_inc(gap_cnt_q) : gap_cnt_q;
  assign out_if.edge_total       = entry_gap ? edge_cnt_q : sepu_pkg::sat_inc(edge_cnt_q);
  assign out_if.last             = out_last;

  // ---------------------------------------------------------------------
  // Datapath updates
  // ---------------------------------------------------------------------
  logic clear_all;

  // Drop all tracking state once the final sample of a capture is done.
  assign clear_all =
      ((state_q == sepu_pkg::ST_IDLE) && in_xfer && in_if.end_of_capture
        && !conv_needed && !first_hold_zero)
   || ((state_q == sepu_pkg::ST_POST) && eoc_q && !emit_post)
   || ((state_q == sepu_pkg::ST_EMIT) && out_xfer && out_last && eoc_q);

  always_comb begin
    latch_d     = latch_q;
    edge_seen_d = edge_seen_q;
    delta_d     = delta_q;
    runt_d      = runt_q;
    gap_cnt_d   = gap_cnt_q;
    edge_cnt_d  = edge_cnt_q;
    hold_d      = hold_q;
    eoc_d       = eoc_q;
    extra_d     = extra_q;
    remain_d    = remain_q;

    case (state_q)
      sepu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (go_hi) begin
            latch_d = sepu_pkg::LATCH_HIGH;
          end else if (go_lo) begin
            latch_d = sepu_pkg::LATCH_LOW;
          end
          if (edge_det) begin
            edge_seen_d = 1'b1;
          end
          // Restart timing on any edge; the conversion captured the old count.
          delta_d  = edge_det ? '0 : delta_inc;
          eoc_d    = in_if.end_of_capture;
          hold_d   = !(edge_det && edge_seen_q);
          extra_d  = 1'b0;
          remain_d = '0;
        end
      end
      sepu_pkg::ST_POST: begin
        remain_d = t_sum;
        if (!hold_q) begin
          if (t_is_runt) begin
            // Fold the runt into the next duration.
            runt_d = t_sum[sepu_pkg::MIN_W-1:0];
            hold_d = 1'b1;
          end else begin
            runt_d  = '0;
            extra_d = eoc_q && gap_t_zero;
          end
        end
      end
      sepu_pkg::ST_EMIT: begin
        if (out_xfer) begin
          if (entry_gap) begin
            gap_cnt_d = sepu_pkg::sat_inc(gap_cnt_q);
          end else begin
            edge_cnt_d = sepu_pkg::sat_inc(edge_cnt_q);
          end
          if (more_chunks) begin
            remain_d = remain_q - DUR_MAX_T;
          end else if (extra_q) begin
            remain_d = '0;
            hold_d   = 1'b1;
            extra_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase

    if (clear_all) begin
      latch_d     = sepu_pkg::LATCH_NONE;
      edge_seen_d = 1'b0;
      delta_d     = '0;
      runt_d      = '0;
      gap_cnt_d   = '0;
      edge_cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sepu_pkg::ST_IDLE;
      latch_q     <= sepu_pkg::LATCH_NONE;
      edge_seen_q <= 1'b0;
      delta_q     <= '0;
      runt_q      <= '0;
      gap_cnt_q   <= '0;
      edge_cnt_q  <= '0;
      hold_q      <= 1'b0;
      eoc_q       <= 1'b0;
      extra_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      latch_q     <= latch_d;
      edge_seen_q <= edge_seen_d;
      delta_q     <= delta_d;
      runt_q      <= runt_d;
      gap_cnt_q   <= gap_cnt_d;
      edge_cnt_q  <= edge_cnt_d;
      hold_q      <= hold_d;
      eoc_q       <= eoc_d;
      extra_q     <= extra_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid)
    else $error("input taken while entries are pending");

  a_chain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_if.last |=> out_if.valid)
    else $error("entry chain ended without a last flag");

  a_chain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_if.last |=> in_if.ready && !out_if.valid)
    else $error("entries continued after the last flag");

  a_conv_in_conv_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == sepu_pkg::ST_CONV)
    else $error("conversion finished outside the wait state");

endmodule

[rtl/sepu_conv.sv]
// Sample distance to T-states: one multiply, then a restoring divider that
// retires one quotient bit per cycle.
module sepu_conv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sepu_pkg::DELTA_W-1:0]    delta_i,
  input  logic [sepu_pkg::RATE_W-1:0]     rate_i,
  output logic                            done_o,
  output logic [sepu_pkg::TST_W-1:0]      quot_o
);

  sepu_pkg::conv_state_e state_q, state_d;
  logic [sepu_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [sepu_pkg::DELTA_W-1:0]   delta_q;
  logic [sepu_pkg::NUM_W-1:0]     num_q;
  logic [sepu_pkg::RATE_W-1:0]    rem_q;

  logic [sepu_pkg::RATE_W:0]      trial;
  logic [sepu_pkg::RATE_W:0]      diff;
  logic                           fits;
  logic                           div_last;

  assign trial    = {rem_q, num_q[sepu_pkg::NUM_W-1]};
  assign fits     = trial >= {1'b0, rate_i};
  assign diff     = trial - {1'b0, rate_i};
  assign div_last = cnt_q == sepu_pkg::DIV_CNT_W'(sepu_pkg::NUM_W - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sepu_pkg::CV_IDLE: if (start_i) state_d = sepu_pkg::CV_MUL;
      sepu_pkg::CV_MUL:  state_d = sepu_pkg::CV_DIV;
      sepu_pkg::CV_DIV:  if (div_last) state_d = sepu_pkg::CV_DONE;
      sepu_pkg::CV_DONE: state_d = sepu_pkg::CV_IDLE;
      default:           state_d = sepu_pkg::CV_IDLE;
    endcase
  end

  always_comb begin
    done_o = state_q == sepu_pkg::CV_DONE;
    quot_o = num_q[sepu_pkg::TST_W-1:0];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == sepu_pkg::CV_MUL) begin
      cnt_d = '0;
    end else if (state_q == sepu_pkg::CV_DIV) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sepu_pkg::CV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Numerator is delta * clock + rate/2 so the quotient rounds to nearest.
  always_ff @(posedge clk_i) begin
    if (state_q == sepu_pkg::CV_IDLE && start_i) begin
      delta_q <= delta_i;
    end
    if (state_q == sepu_pkg::CV_MUL) begin
      num_q <= sepu_pkg::NUM_W'(delta_q) * sepu_pkg::NUM_W'(sepu_pkg::TSTATE_CLOCK_HZ)
             + sepu_pkg::NUM_W'(rate_i >> 1);
      rem_q <= '0;
    end else if (state_q == sepu_pkg::CV_DIV) begin
      num_q <= {num_q[sepu_pkg::NUM_W-2:0], fits};
      rem_q <= fits ? diff[sepu_pkg::RATE_W-1:0] : trial[sepu_pkg::RATE_W-1:0];
    end
  end

  a_rem_below_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sepu_pkg::CV_DIV && cnt_q != '0 |-> rem_q < rate_i)
    else $error("divider remainder reached the divisor");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == sepu_pkg::CV_IDLE)
    else $error("conversion started while busy");

  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(state_q) == sepu_pkg::CV_DIV && $past(div_last))
    else $error("conversion finished without a full division");

endmodule
